@@ rtl/core/wvsf_pkg.sv @@
// Shared types, codes and helpers for the wake/VAD session machine.
// Depends on nothing; every other file of the block refers to it by scoped names.

package wvsf_pkg;

	localparam int TIMER_BITS = 24;
	localparam int CFG_BITS = 24;

	// Event queue between the front and the back part.
	localparam int FQ_DEPTH = 2;
	localparam int FQ_AW = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
	localparam int FQ_CW = $clog2(FQ_DEPTH + 1);

	// Notice queue toward the result side; it must hold at least two entries.
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW = $clog2(OQ_DEPTH);
	localparam int OQ_CW = $clog2(OQ_DEPTH + 1);

	// Session states.
	localparam logic [2:0] S_IDLE         = 3'd0;
	localparam logic [2:0] S_WOKEN        = 3'd1;
	localparam logic [2:0] S_WAIT_SPEECH  = 3'd2;
	localparam logic [2:0] S_SPEAKING     = 3'd3;
	localparam logic [2:0] S_WAIT_SILENCE = 3'd4;
	localparam logic [2:0] S_WAIT_SLEEP   = 3'd5;

	// Event codes.
	localparam logic [2:0] E_SILENCE  = 3'd0;
	localparam logic [2:0] E_SPEECH   = 3'd1;
	localparam logic [2:0] E_WAKE     = 3'd2;
	localparam logic [2:0] E_WAKE_EXP = 3'd3;
	localparam logic [2:0] E_VAD_EXP  = 3'd4;
	localparam logic [2:0] E_OTHER    = 3'd5;

	// Notice codes.
	localparam logic [1:0] N_WAKE_START   = 2'd0;
	localparam logic [1:0] N_WAKE_END     = 2'd1;
	localparam logic [1:0] N_SPEECH_START = 2'd2;
	localparam logic [1:0] N_SPEECH_END   = 2'd3;

	// Voice activity classes.
	localparam logic [1:0] VAD_SILENCE = 2'd0;
	localparam logic [1:0] VAD_SPEECH  = 2'd1;

	// Configuration register indexes.
	localparam logic [1:0] REG_WAKE_WINDOW    = 2'd0;
	localparam logic [1:0] REG_SLEEP_WINDOW   = 2'd1;
	localparam logic [1:0] REG_SPEECH_CONFIRM = 2'd2;
	localparam logic [1:0] REG_SILENCE_CONFIRM = 2'd3;

	typedef logic [TIMER_BITS-1:0] tcount_t;
	typedef logic [CFG_BITS-1:0] cfg_word_t;

	typedef struct packed {
		cfg_word_t wake_window;
		cfg_word_t sleep_window;
		cfg_word_t speech_confirm;
		cfg_word_t silence_confirm;
	} cfg_t;

	// One classified item as it waits between front and back.
	typedef struct packed {
		logic        is_tick;
		logic [2:0]  ev;
		logic [7:0]  word_index;
		logic [3:0]  model_index;
		logic [31:0] volume_word;
		logic        wake_enabled;
	} ev_item_t;

	// Head of the event queue as the back part sees it.
	typedef struct packed {
		logic     valid;
		ev_item_t item;
	} fq_head_t;

	// One notice as it waits for the result side.
	typedef struct packed {
		logic [1:0]  notice;
		logic [7:0]  word_index;
		logic [3:0]  model_index;
		logic [31:0] volume;
		logic [2:0]  session_state;
		logic        last_notice;
	} notice_t;

	// A window larger than the counter saturates to the counter's maximum.
	function automatic tcount_t timer_load(input cfg_word_t ms);
		logic [32:0] ext;
		logic [32:0] maxv;
		ext = 33'(ms);
		maxv = 33'({TIMER_BITS{1'b1}});
		if (ext > maxv) begin
			return tcount_t'(maxv);
		end
		return tcount_t'(ext);
	endfunction

endpackage

@@ rtl/core/wvsf_front.sv @@
// Front part: classifies each accepted item into an event and queues it.
// Depends on wvsf_pkg for the item type, event codes and queue depth.

module wvsf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               action,
	input  logic               wake_detected,
	input  logic [1:0]         vad_class,
	input  logic [7:0]         word_index,
	input  logic [3:0]         model_index,
	input  logic [31:0]        volume_word,
	input  logic               wake_enabled,
	output wvsf_pkg::fq_head_t head,
	input  logic               head_pop
);

	wvsf_pkg::ev_item_t fq_mem_q [wvsf_pkg::FQ_DEPTH];
	logic [wvsf_pkg::FQ_AW-1:0] wr_ptr_q;
	logic [wvsf_pkg::FQ_AW-1:0] rd_ptr_q;
	logic [wvsf_pkg::FQ_CW-1:0] cnt_q;
	wvsf_pkg::ev_item_t new_item;
	logic do_push;
	logic do_pop;

	// Wake word wins over silence, silence over speech; anything else is "other".
	always_comb begin
		new_item.is_tick = action;
		priority if (wake_detected) begin
			new_item.ev = wvsf_pkg::E_WAKE;
		end else if (vad_class == wvsf_pkg::VAD_SILENCE) begin
			new_item.ev = wvsf_pkg::E_SILENCE;
		end else if (vad_class == wvsf_pkg::VAD_SPEECH) begin
			new_item.ev = wvsf_pkg::E_SPEECH;
		end else begin
			new_item.ev = wvsf_pkg::E_OTHER;
		end
		new_item.word_index = word_index;
		new_item.model_index = model_index;
		new_item.volume_word = volume_word;
		new_item.wake_enabled = wake_enabled;
	end

	assign full = (cnt_q == wvsf_pkg::FQ_CW'(wvsf_pkg::FQ_DEPTH));
	assign do_push = push && !full;
	assign do_pop = head_pop && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.item = fq_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			fq_mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == wvsf_pkg::FQ_AW'(wvsf_pkg::FQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + wvsf_pkg::FQ_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == wvsf_pkg::FQ_AW'(wvsf_pkg::FQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + wvsf_pkg::FQ_AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + wvsf_pkg::FQ_CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - wvsf_pkg::FQ_CW'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_fq_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= wvsf_pkg::FQ_CW'(wvsf_pkg::FQ_DEPTH))
		else $error("event queue count above its depth");
`endif

endmodule

@@ rtl/core/wvsf_back.sv @@
// Back part: session machine, the two millisecond timers and the registers.
// Depends on wvsf_pkg for state, event and notice codes and the shared types.

module wvsf_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic [1:0]              cfg_index,
	input  logic [23:0]             cfg_data,
	input  wvsf_pkg::fq_head_t      head,
	output logic                    head_pop,
	input  logic                    room,
	output logic [1:0]              push_cnt,
	output wvsf_pkg::notice_t       push0,
	output wvsf_pkg::notice_t       push1
);

	typedef struct packed {
		logic [2:0]        session;
		logic [2:0]        prev;
		wvsf_pkg::tcount_t wake_cnt;
		logic              wake_run;
		wvsf_pkg::tcount_t vad_cnt;
		logic              vad_run;
	} sess_t;

	typedef struct packed {
		sess_t      st;
		logic       nv;
		logic [1:0] ncode;
		logic       kill;
	} ev_res_t;

	sess_t st_q;
	sess_t st_d;
	sess_t tk;
	wvsf_pkg::cfg_t cfg_q;
	ev_res_t r1;
	ev_res_t r2;
	logic wake_due;
	logic vad_due;
	logic take;
	wvsf_pkg::notice_t n1;
	wvsf_pkg::notice_t n2;

	function automatic sess_t wake_stop(input sess_t s);
		s.wake_run = 1'b0;
		s.wake_cnt = '0;
		return s;
	endfunction

	function automatic sess_t vad_stop(input sess_t s);
		s.vad_run = 1'b0;
		s.vad_cnt = '0;
		return s;
	endfunction

	// The window depends on the state just entered.
	function automatic sess_t wake_start(input sess_t s, input wvsf_pkg::cfg_t c);
		wvsf_pkg::cfg_word_t t;
		t = '0;
		if (s.session == wvsf_pkg::S_WOKEN) begin
			t = c.wake_window;
		end else if (s.session == wvsf_pkg::S_WAIT_SLEEP) begin
			t = c.sleep_window;
		end
		s = wake_stop(s);
		if (t != '0) begin
			s.wake_cnt = wvsf_pkg::timer_load(t);
			s.wake_run = 1'b1;
		end
		return s;
	endfunction

	function automatic sess_t vad_arm(input sess_t s, input wvsf_pkg::cfg_t c);
		wvsf_pkg::cfg_word_t t;
		t = '0;
		if (s.session == wvsf_pkg::S_WAIT_SPEECH) begin
			t = c.speech_confirm;
		end else if (s.session == wvsf_pkg::S_WAIT_SILENCE) begin
			t = c.silence_confirm;
		end
		s = vad_stop(s);
		if (t != '0) begin
			s.vad_cnt = wvsf_pkg::timer_load(t);
			s.vad_run = 1'b1;
		end
		return s;
	endfunction

	function automatic ev_res_t no_event(input sess_t s);
		ev_res_t r;
		r.st = s;
		r.nv = 1'b0;
		r.ncode = wvsf_pkg::N_WAKE_START;
		r.kill = 1'b0;
		return r;
	endfunction

	// One event through the session machine. The kill flag tells that the
	// VAD timer was stopped or restarted, which cancels a VAD expiry that is
	// still waiting on the same tick.
	function automatic ev_res_t handle_ev(input logic [2:0] ev, input sess_t s_in,
		input wvsf_pkg::cfg_t c, input logic wake_en);
		ev_res_t r;
		sess_t s;
		r = no_event(s_in);
		s = s_in;
		if (ev != s_in.prev) begin
			s.prev = ev;
			if (ev == wvsf_pkg::E_WAKE && s.session != wvsf_pkg::S_IDLE) begin
				s = wake_stop(s);
				s = vad_stop(s);
				r.kill = 1'b1;
				s.session = wvsf_pkg::S_IDLE;
			end
			unique case (s.session)
				wvsf_pkg::S_IDLE: begin
					if (ev == wvsf_pkg::E_WAKE) begin
						s.session = wvsf_pkg::S_WOKEN;
						s = wake_start(s, c);
						r.nv = 1'b1;
						r.ncode = wvsf_pkg::N_WAKE_START;
					end else if (ev == wvsf_pkg::E_SPEECH && !wake_en) begin
						if (c.speech_confirm != '0) begin
							s.session = wvsf_pkg::S_WAIT_SPEECH;
							s = vad_arm(s, c);
							r.kill = 1'b1;
						end else begin
							s.session = wvsf_pkg::S_SPEAKING;
							r.nv = 1'b1;
							r.ncode = wvsf_pkg::N_SPEECH_START;
						end
					end
				end
				wvsf_pkg::S_WOKEN: begin
					if (ev == wvsf_pkg::E_SPEECH) begin
						if (c.speech_confirm != '0) begin
							s.session = wvsf_pkg::S_WAIT_SPEECH;
							s = vad_arm(s, c);
							r.kill = 1'b1;
						end else begin
							s.session = wvsf_pkg::S_SPEAKING;
							r.nv = 1'b1;
							r.ncode = wvsf_pkg::N_SPEECH_START;
						end
					end else if (ev == wvsf_pkg::E_WAKE_EXP) begin
						s.session = wvsf_pkg::S_IDLE;
						s = wake_stop(s);
						r.nv = 1'b1;
						r.ncode = wvsf_pkg::N_WAKE_END;
					end
				end
				wvsf_pkg::S_WAIT_SPEECH: begin
					if (ev == wvsf_pkg::E_SILENCE) begin
						s.session = wvsf_pkg::S_WOKEN;
					end else if (ev == wvsf_pkg::E_VAD_EXP) begin
						s.session = wvsf_pkg::S_SPEAKING;
						s = wake_stop(s);
						r.nv = 1'b1;
						r.ncode = wvsf_pkg::N_SPEECH_START;
					end else if (ev == wvsf_pkg::E_WAKE_EXP) begin
						s.session = wvsf_pkg::S_IDLE;
						s = vad_stop(s);
						r.kill = 1'b1;
						r.nv = 1'b1;
						r.ncode = wvsf_pkg::N_WAKE_END;
					end
				end
				wvsf_pkg::S_SPEAKING: begin
					if (ev == wvsf_pkg::E_SILENCE) begin
						if (c.silence_confirm != '0) begin
							s.session = wvsf_pkg::S_WAIT_SILENCE;
							s = vad_arm(s, c);
							r.kill = 1'b1;
						end else begin
							s.session = wvsf_pkg::S_WAIT_SLEEP;
							s = wake_start(s, c);
							r.nv = 1'b1;
							r.ncode = wvsf_pkg::N_SPEECH_END;
						end
					end
				end
				wvsf_pkg::S_WAIT_SILENCE: begin
					if (ev == wvsf_pkg::E_SPEECH) begin
						s.session = wvsf_pkg::S_SPEAKING;
						s = vad_stop(s);
						r.kill = 1'b1;
					end else if (ev == wvsf_pkg::E_VAD_EXP) begin
						if (wake_en) begin
							s.session = wvsf_pkg::S_WAIT_SLEEP;
							s = wake_start(s, c);
						end else begin
							s.session = wvsf_pkg::S_IDLE;
						end
						r.nv = 1'b1;
						r.ncode = wvsf_pkg::N_SPEECH_END;
					end
				end
				wvsf_pkg::S_WAIT_SLEEP: begin
					if (ev == wvsf_pkg::E_SPEECH) begin
						s.session = wvsf_pkg::S_WAIT_SPEECH;
						s = vad_arm(s, c);
						r.kill = 1'b1;
					end else if (ev == wvsf_pkg::E_WAKE_EXP) begin
						s.session = wvsf_pkg::S_IDLE;
						s = vad_stop(s);
						r.kill = 1'b1;
						r.nv = 1'b1;
						r.ncode = wvsf_pkg::N_WAKE_END;
					end
				end
				default: begin
					s.session = wvsf_pkg::S_IDLE;
				end
			endcase
			r.st = s;
		end
		return r;
	endfunction

	function automatic wvsf_pkg::notice_t make_notice(input ev_res_t r,
		input wvsf_pkg::ev_item_t it);
		wvsf_pkg::notice_t n;
		logic ws;
		ws = (r.ncode == wvsf_pkg::N_WAKE_START);
		n.notice = r.ncode;
		n.word_index = ws ? it.word_index : '0;
		n.model_index = ws ? it.model_index : '0;
		n.volume = ws ? it.volume_word : '0;
		n.session_state = r.st.session;
		n.last_notice = 1'b0;
		return n;
	endfunction

	// Room for two notices is required before an item is taken.
	assign take = head.valid && room;
	assign head_pop = take;

	always_comb begin
		tk = st_q;
		wake_due = 1'b0;
		vad_due = 1'b0;
		if (tk.wake_run) begin
			tk.wake_cnt = (tk.wake_cnt == '0) ? '0 : tk.wake_cnt - wvsf_pkg::tcount_t'(1);
			if (tk.wake_cnt == '0) begin
				tk.wake_run = 1'b0;
				wake_due = 1'b1;
			end
		end
		if (tk.vad_run) begin
			tk.vad_cnt = (tk.vad_cnt == '0) ? '0 : tk.vad_cnt - wvsf_pkg::tcount_t'(1);
			if (tk.vad_cnt == '0) begin
				tk.vad_run = 1'b0;
				vad_due = 1'b1;
			end
		end

		if (head.item.is_tick) begin
			// Wake expiry goes first; it may cancel the VAD expiry.
			r1 = wake_due ? handle_ev(wvsf_pkg::E_WAKE_EXP, tk, cfg_q, head.item.wake_enabled)
				: no_event(tk);
			r2 = (vad_due && !r1.kill) ?
				handle_ev(wvsf_pkg::E_VAD_EXP, r1.st, cfg_q, head.item.wake_enabled)
				: no_event(r1.st);
		end else begin
			r1 = handle_ev(head.item.ev, st_q, cfg_q, head.item.wake_enabled);
			r2 = no_event(r1.st);
		end
		st_d = r2.st;

		n1 = make_notice(r1, head.item);
		n2 = make_notice(r2, head.item);
		n2.last_notice = 1'b1;

		push_cnt = take ? (2'(r1.nv) + 2'(r2.nv)) : 2'd0;
		push0 = r1.nv ? n1 : n2;
		push0.last_notice = !(r1.nv && r2.nv);
		push1 = n2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.session <= wvsf_pkg::S_IDLE;
			st_q.prev <= wvsf_pkg::E_OTHER;
			st_q.wake_cnt <= '0;
			st_q.wake_run <= 1'b0;
			st_q.vad_cnt <= '0;
			st_q.vad_run <= 1'b0;
		end else if (take) begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				wvsf_pkg::REG_WAKE_WINDOW:     cfg_q.wake_window <= cfg_data;
				wvsf_pkg::REG_SLEEP_WINDOW:    cfg_q.sleep_window <= cfg_data;
				wvsf_pkg::REG_SPEECH_CONFIRM:  cfg_q.speech_confirm <= cfg_data;
				wvsf_pkg::REG_SILENCE_CONFIRM: cfg_q.silence_confirm <= cfg_data;
				default:                       cfg_q <= cfg_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_wake_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.wake_run |-> (st_q.wake_cnt != '0))
		else $error("wake timer running with a zero count");
	a_vad_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.vad_run |-> (st_q.vad_cnt != '0))
		else $error("VAD timer running with a zero count");
`endif

endmodule

@@ rtl/core/wvsf_outq.sv @@
// Notice queue: takes up to two notices a cycle from the back part, hands one out.
// Depends on wvsf_pkg for the notice type and the queue depth.

module wvsf_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_cnt,
	input  wvsf_pkg::notice_t push0,
	input  wvsf_pkg::notice_t push1,
	output logic              room,
	output logic              empty,
	input  logic              pop,
	output wvsf_pkg::notice_t head
);

	wvsf_pkg::notice_t oq_mem_q [wvsf_pkg::OQ_DEPTH];
	logic [wvsf_pkg::OQ_AW-1:0] wr_ptr_q;
	logic [wvsf_pkg::OQ_AW-1:0] rd_ptr_q;
	logic [wvsf_pkg::OQ_CW-1:0] cnt_q;
	logic [wvsf_pkg::OQ_AW-1:0] wr_next;
	logic [wvsf_pkg::OQ_AW-1:0] wr_next2;
	logic do_pop;

	assign wr_next = (wr_ptr_q == wvsf_pkg::OQ_AW'(wvsf_pkg::OQ_DEPTH - 1)) ?
		'0 : wr_ptr_q + wvsf_pkg::OQ_AW'(1);
	assign wr_next2 = (wr_next == wvsf_pkg::OQ_AW'(wvsf_pkg::OQ_DEPTH - 1)) ?
		'0 : wr_next + wvsf_pkg::OQ_AW'(1);

	assign empty = (cnt_q == '0);
	assign room = (cnt_q <= wvsf_pkg::OQ_CW'(wvsf_pkg::OQ_DEPTH - 2));
	assign do_pop = pop && !empty;
	assign head = oq_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			oq_mem_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			oq_mem_q[wr_next] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push_cnt == 2'd1) begin
				wr_ptr_q <= wr_next;
			end else if (push_cnt == 2'd2) begin
				wr_ptr_q <= wr_next2;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == wvsf_pkg::OQ_AW'(wvsf_pkg::OQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + wvsf_pkg::OQ_AW'(1);
			end
			cnt_q <= cnt_q + wvsf_pkg::OQ_CW'(push_cnt) - wvsf_pkg::OQ_CW'(do_pop);
		end
	end

`ifndef ASSERT_OFF
	a_oq_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= wvsf_pkg::OQ_CW'(wvsf_pkg::OQ_DEPTH))
		else $error("notice queue count above its depth");
	a_oq_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) |-> room)
		else $error("notices pushed without room for two");
`endif

endmodule

@@ rtl/core/wake_vad_session_fsm_core.sv @@
// Top level of the wake-word / voice-activity session machine.
// Depends on wvsf_pkg, wvsf_front, wvsf_back and wvsf_outq.

// Usage. Input items enter like a queue write: an item is taken at a rising edge
// where push is high and full is low. An item is either a detector result
// (action low) or a one-millisecond tick (action high). Notices leave like a
// queue read: while empty is low the oldest notice is on the result ports, and
// it is taken at an edge where pop is high. One item yields zero, one or two
// notices; last_notice marks the final notice of an item.
// Registers are written through cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high, so a write lands at any edge where cfg_valid is high. Writes
// are meant to happen only while no item is in flight.
// Path: the accepting edge writes the event queue; a later edge, taken once the
// notice queue has room for two notices, carries the item through the session
// step into the notice queue, whose oldest entry drives the result ports.
// Throughput: one item per cycle, set by the session step in the
// back part, as long as the result side pops; the back part takes an item only
// when the notice queue has room for two notices, so a stalled result side
// fills the notice queue, then the two-entry event queue, and then raises full.
// Reset (arst_n low) empties both queues, clears the registers to zero, puts
// the session in idle with both timers stopped; the reset acts asynchronously.

module wake_vad_session_fsm_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic        wake_detected,
	input  logic [1:0]  vad_class,
	input  logic [7:0]  word_index,
	input  logic [3:0]  model_index,
	input  logic [31:0] volume_word,
	input  logic        wake_enabled,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  notice,
	output logic [7:0]  out_word_index,
	output logic [3:0]  out_model_index,
	output logic [31:0] out_volume,
	output logic [2:0]  session_state,
	output logic        last_notice,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	wvsf_pkg::fq_head_t ev_head;
	logic ev_pop;
	logic oq_room;
	logic [1:0] push_cnt;
	wvsf_pkg::notice_t push0;
	wvsf_pkg::notice_t push1;
	wvsf_pkg::notice_t oq_head;

	// The register file never stalls a write.
	assign cfg_ready = 1'b1;

	// Front: classify each item into an event and hold it in a short queue.
	wvsf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.wake_detected(wake_detected),
		.vad_class    (vad_class),
		.word_index   (word_index),
		.model_index  (model_index),
		.volume_word  (volume_word),
		.wake_enabled (wake_enabled),
		.head         (ev_head),
		.head_pop     (ev_pop)
	);

	// Back: one item per cycle, while the notice queue has room, through the timers and the session machine.
	wvsf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.head     (ev_head),
		.head_pop (ev_pop),
		.room     (oq_room),
		.push_cnt (push_cnt),
		.push0    (push0),
		.push1    (push1)
	);

	// Notices wait here until the result side pops them.
	wvsf_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_cnt(push_cnt),
		.push0   (push0),
		.push1   (push1),
		.room    (oq_room),
		.empty   (empty),
		.pop     (pop),
		.head    (oq_head)
	);

	assign notice = oq_head.notice;
	assign out_word_index = oq_head.word_index;
	assign out_model_index = oq_head.model_index;
	assign out_volume = oq_head.volume;
	assign session_state = oq_head.session_state;
	assign last_notice = oq_head.last_notice;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the wake-word / voice-activity session machine.
// Depends on wvsf_pkg and wake_vad_session_fsm_core; it predicts every notice and
// compares it field by field with what the block puts out.

module testbench;
	import wvsf_pkg::*;

	// One input item as the sender offers it.
	typedef struct packed {
		logic        action;
		logic        wake_detected;
		logic [1:0]  vad_class;
		logic [7:0]  word_index;
		logic [3:0]  model_index;
		logic [31:0] volume_word;
		logic        wake_enabled;
	} front_item_t;

	localparam logic ACT_RESULT = 1'b0;
	localparam logic ACT_TICK   = 1'b1;
	localparam logic [1:0] VAD_OTHER  = 2'd2;
	localparam logic [1:0] VAD_UNUSED = 2'd3;
	localparam cfg_word_t WINDOW_MAX = {CFG_BITS{1'b1}};

	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 135;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 400000;

	// Session model plus the list of notices still owed by the block.
	class wake_session_board;
		cfg_word_t wake_win, sleep_win, speech_conf, silence_conf;
		logic [2:0] session;
		logic [2:0] prev_ev;
		tcount_t wake_cnt, vad_cnt;
		bit wake_on, vad_on, vad_due;
		notice_t due_notices[$];
		notice_t step_out[$];
		int mismatches;

		function new();
			wake_win = '0;
			sleep_win = '0;
			speech_conf = '0;
			silence_conf = '0;
			session = S_IDLE;
			prev_ev = E_OTHER;
			wake_cnt = '0;
			vad_cnt = '0;
			wake_on = 0;
			vad_on = 0;
			vad_due = 0;
			mismatches = 0;
		endfunction

		function void set_window(logic [1:0] idx, cfg_word_t data);
			case (idx)
				REG_WAKE_WINDOW: wake_win = data;
				REG_SLEEP_WINDOW: sleep_win = data;
				REG_SPEECH_CONFIRM: speech_conf = data;
				default: silence_conf = data;
			endcase
		endfunction

		function int outstanding();
			return due_notices.size();
		endfunction

		function void emit(logic [1:0] code, front_item_t it);
			notice_t n;
			bit ws;
			ws = (code == N_WAKE_START);
			n.notice = code;
			n.word_index = ws ? it.word_index : '0;
			n.model_index = ws ? it.model_index : '0;
			n.volume = ws ? it.volume_word : '0;
			n.session_state = session;
			n.last_notice = 1'b0;
			step_out.push_back(n);
		endfunction

		function void stop_wake();
			wake_on = 0;
			wake_cnt = '0;
		endfunction

		// Stopping the VAD counter also cancels an expiry seen on the same tick.
		function void stop_vad();
			vad_on = 0;
			vad_cnt = '0;
			vad_due = 0;
		endfunction

		function void arm_wake();
			cfg_word_t t;
			t = '0;
			if (session == S_WOKEN)
				t = wake_win;
			else if (session == S_WAIT_SLEEP)
				t = sleep_win;
			stop_wake();
			if (t != '0) begin
				wake_cnt = t;
				wake_on = 1;
			end
		endfunction

		function void arm_vad();
			cfg_word_t t;
			t = '0;
			if (session == S_WAIT_SPEECH)
				t = speech_conf;
			else if (session == S_WAIT_SILENCE)
				t = silence_conf;
			stop_vad();
			if (t != '0) begin
				vad_cnt = t;
				vad_on = 1;
			end
		endfunction

		function void speech_heard(front_item_t it);
			if (speech_conf != '0) begin
				session = S_WAIT_SPEECH;
				arm_vad();
			end else begin
				session = S_SPEAKING;
				emit(N_SPEECH_START, it);
			end
		endfunction

		function void apply_event(logic [2:0] ev, front_item_t it);
			if (ev == prev_ev)
				return;
			prev_ev = ev;
			if (ev == E_WAKE && session != S_IDLE) begin
				stop_wake();
				stop_vad();
				session = S_IDLE;
			end
			case (session)
				S_IDLE: begin
					if (ev == E_WAKE) begin
						session = S_WOKEN;
						arm_wake();
						emit(N_WAKE_START, it);
					end else if (ev == E_SPEECH && !it.wake_enabled) begin
						speech_heard(it);
					end
				end
				S_WOKEN: begin
					if (ev == E_SPEECH) begin
						speech_heard(it);
					end else if (ev == E_WAKE_EXP) begin
						session = S_IDLE;
						stop_wake();
						emit(N_WAKE_END, it);
					end
				end
				S_WAIT_SPEECH: begin
					if (ev == E_SILENCE) begin
						session = S_WOKEN;
					end else if (ev == E_VAD_EXP) begin
						session = S_SPEAKING;
						stop_wake();
						emit(N_SPEECH_START, it);
					end else if (ev == E_WAKE_EXP) begin
						session = S_IDLE;
						stop_vad();
						emit(N_WAKE_END, it);
					end
				end
				S_SPEAKING: begin
					if (ev == E_SILENCE) begin
						if (silence_conf != '0) begin
							session = S_WAIT_SILENCE;
							arm_vad();
						end else begin
							session = S_WAIT_SLEEP;
							arm_wake();
							emit(N_SPEECH_END, it);
						end
					end
				end
				S_WAIT_SILENCE: begin
					if (ev == E_SPEECH) begin
						session = S_SPEAKING;
						stop_vad();
					end else if (ev == E_VAD_EXP) begin
						if (it.wake_enabled) begin
							session = S_WAIT_SLEEP;
							arm_wake();
						end else begin
							session = S_IDLE;
						end
						emit(N_SPEECH_END, it);
					end
				end
				S_WAIT_SLEEP: begin
					if (ev == E_SPEECH) begin
						session = S_WAIT_SPEECH;
						arm_vad();
					end else if (ev == E_WAKE_EXP) begin
						session = S_IDLE;
						stop_vad();
						emit(N_WAKE_END, it);
					end
				end
				default: session = S_IDLE;
			endcase
		endfunction

		// Called for every item the block accepts; queues the notices it owes.
		function void take_item(front_item_t it);
			bit wake_due;
			step_out.delete();
			if (it.action == ACT_RESULT) begin
				if (it.wake_detected)
					apply_event(E_WAKE, it);
				else if (it.vad_class == VAD_SILENCE)
					apply_event(E_SILENCE, it);
				else if (it.vad_class == VAD_SPEECH)
					apply_event(E_SPEECH, it);
				else
					apply_event(E_OTHER, it);
			end else begin
				wake_due = 0;
				vad_due = 0;
				if (wake_on) begin
					wake_cnt = (wake_cnt == '0) ? '0 : wake_cnt - tcount_t'(1);
					if (wake_cnt == '0) begin
						wake_on = 0;
						wake_due = 1;
					end
				end
				if (vad_on) begin
					vad_cnt = (vad_cnt == '0) ? '0 : vad_cnt - tcount_t'(1);
					if (vad_cnt == '0) begin
						vad_on = 0;
						vad_due = 1;
					end
				end
				if (wake_due)
					apply_event(E_WAKE_EXP, it);
				if (vad_due) begin
					vad_due = 0;
					apply_event(E_VAD_EXP, it);
				end
			end
			if (step_out.size() > 0)
				step_out[step_out.size() - 1].last_notice = 1'b1;
			foreach (step_out[i])
				due_notices.push_back(step_out[i]);
		endfunction

		function void compare_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				mismatches++;
				$error("%s: expected %0d, got %0d", name, want, got);
			end
		endfunction

		// Called for every notice the result side accepts.
		function void match_notice(notice_t got);
			notice_t want;
			if (due_notices.size() == 0) begin
				mismatches++;
				$error("notice: none expected, got %0d", got.notice);
				return;
			end
			want = due_notices.pop_front();
			compare_field("notice", 64'(want.notice), 64'(got.notice));
			compare_field("out_word_index", 64'(want.word_index), 64'(got.word_index));
			compare_field("out_model_index", 64'(want.model_index), 64'(got.model_index));
			compare_field("out_volume", 64'(want.volume), 64'(got.volume));
			compare_field("session_state", 64'(want.session_state),
				64'(got.session_state));
			compare_field("last_notice", 64'(want.last_notice), 64'(got.last_notice));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        action;
	logic        wake_detected;
	logic [1:0]  vad_class;
	logic [7:0]  word_index;
	logic [3:0]  model_index;
	logic [31:0] volume_word;
	logic        wake_enabled;
	logic        empty;
	logic        pop;
	logic [1:0]  notice;
	logic [7:0]  out_word_index;
	logic [3:0]  out_model_index;
	logic [31:0] out_volume;
	logic [2:0]  session_state;
	logic        last_notice;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	wake_vad_session_fsm_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.action(action),
		.wake_detected(wake_detected),
		.vad_class(vad_class),
		.word_index(word_index),
		.model_index(model_index),
		.volume_word(volume_word),
		.wake_enabled(wake_enabled),
		.empty(empty),
		.pop(pop),
		.notice(notice),
		.out_word_index(out_word_index),
		.out_model_index(out_model_index),
		.out_volume(out_volume),
		.session_state(session_state),
		.last_notice(last_notice),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	wake_session_board board;

	// Shared pacing knobs. gap_odds of N means an idle burst before roughly one
	// item in N on the input side, and a stall before one pop in N on the result
	// side; zero turns idling off on both sides.
	int gap_odds;
	bit mode_wake_en;
	bit hold_req;
	int items_sent;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: a run that is still going at the limit has lost a notice or hung.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side. Pop is changed on falling edges only; the notice fields are
	// read right after the rising edge, before the block updates them. A hold
	// request from the stimulus makes this side stop popping for a long stretch
	// so that both internal queues fill up and the block raises full.
	initial begin : result_side
		int stall_left;
		int hold_left;
		bit hold_taken;
		stall_left = 0;
		hold_left = 0;
		hold_taken = 0;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
				stall_left = int'($urandom_range(1, 16)) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
			@(posedge clk);
			if (pop && !empty)
				board.match_notice('{notice, out_word_index, out_model_index, out_volume,
					session_state, last_notice});
		end
	end

	// Input fields carry random values while push is low, so that the block is
	// seen to ignore them.
	task automatic idle_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			push <= 1'b0;
			action <= 1'($urandom_range(0, 1));
			wake_detected <= 1'($urandom_range(0, 1));
			vad_class <= 2'($urandom_range(0, 3));
			word_index <= 8'($urandom);
			model_index <= 4'($urandom);
			volume_word <= 32'($urandom);
			wake_enabled <= 1'($urandom_range(0, 1));
		end
	endtask

	// Offers one item and returns at the rising edge that accepts it. Push is
	// left high so that the next item can follow without a gap.
	task automatic send(input front_item_t it);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
			idle_sender($urandom_range(1, 16));
		@(negedge clk);
		push <= 1'b1;
		action <= it.action;
		wake_detected <= it.wake_detected;
		vad_class <= it.vad_class;
		word_index <= it.word_index;
		model_index <= it.model_index;
		volume_word <= it.volume_word;
		wake_enabled <= it.wake_enabled;
		@(posedge clk);
		while (full)
			@(posedge clk);
		board.take_item(it);
		items_sent++;
	endtask

	// Stops offering items and waits until every owed notice has come out. Items
	// that cause no notice may still be in the block, so it also waits out SETTLE_CYCLES.
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input cfg_word_t data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_window(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_windows(input cfg_word_t wake_w, input cfg_word_t sleep_w,
			input cfg_word_t speech_c, input cfg_word_t silence_c);
		write_reg(REG_WAKE_WINDOW, wake_w);
		write_reg(REG_SLEEP_WINDOW, sleep_w);
		write_reg(REG_SPEECH_CONFIRM, speech_c);
		write_reg(REG_SILENCE_CONFIRM, silence_c);
	endtask

	// The payload that only a wake start passes through is always random.
	function automatic front_item_t make_item(input logic act, input logic wake,
			input logic [1:0] vad, input logic wake_en);
		front_item_t it;
		it.action = act;
		it.wake_detected = wake;
		it.vad_class = vad;
		it.word_index = 8'($urandom);
		it.model_index = 4'($urandom);
		it.volume_word = 32'($urandom);
		it.wake_enabled = wake_en;
		return it;
	endfunction

	// The front end's mode holds for a phase but now and then flips for one item.
	function automatic logic pick_mode();
		return mode_wake_en ^ ($urandom_range(0, 9) == 0);
	endfunction

	function automatic cfg_word_t pick_window();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return '0;
		if (r == 9)
			return cfg_word_t'($urandom);
		return cfg_word_t'($urandom_range(1, 8));
	endfunction

	// Ticks carry random detector fields, which must not matter.
	task automatic send_ticks(input int count);
		repeat (count)
			send(make_item(ACT_TICK, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
				pick_mode()));
	endtask

	// A plausible conversation: usually a wake word, then rounds of speech and
	// silence separated by runs of ticks, so the timers get to expire in every
	// state of the session.
	task automatic run_session();
		int rounds;
		int span;
		span = $urandom_range(0, 1) ? 3 : 12;
		rounds = $urandom_range(1, 3);
		if ($urandom_range(0, 7) != 0)
			send(make_item(ACT_RESULT, 1'b1, 2'($urandom_range(0, 3)), pick_mode()));
		repeat (rounds) begin
			send_ticks($urandom_range(0, span));
			send(make_item(ACT_RESULT, 1'b0, VAD_SPEECH, pick_mode()));
			send_ticks($urandom_range(0, span));
			if ($urandom_range(0, 5) == 0)
				send(make_item(ACT_RESULT, 1'b0, 2'($urandom_range(VAD_OTHER, VAD_UNUSED)),
					pick_mode()));
			send(make_item(ACT_RESULT, 1'b0, VAD_SILENCE, pick_mode()));
			send_ticks($urandom_range(0, span));
		end
		send_ticks($urandom_range(0, 2 * span));
	endtask

	task automatic send_noise();
		send(make_item(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
			2'($urandom_range(0, 3)), pick_mode()));
	endtask

	initial begin : stimulus
		front_item_t it;
		int target;
		board = new();
		gap_odds = 4;
		mode_wake_en = 1'b0;
		hold_req = 0;
		items_sent = 0;
		arst_n = 1'b0;
		push = 1'b0;
		action = 1'b0;
		wake_detected = 1'b0;
		vad_class = '0;
		word_index = '0;
		model_index = '0;
		volume_word = '0;
		wake_enabled = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_WAKE_WINDOW;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, first with every window at its reset value of zero.
		// With the wake word not required, speech in idle starts at once, a
		// repeated speech result is dropped, and silence ends speech at once.
		send(make_item(ACT_RESULT, 1'b0, VAD_SPEECH, 1'b0));
		send(make_item(ACT_RESULT, 1'b0, VAD_SPEECH, 1'b0));
		send(make_item(ACT_RESULT, 1'b0, VAD_SILENCE, 1'b0));
		// The unused voice class counts as other.
		send(make_item(ACT_RESULT, 1'b0, VAD_UNUSED, 1'b0));
		// A wake word outside idle resets the session and then wakes it; the
		// payload fields sit at their maximum, and a second wake word is dropped.
		it = make_item(ACT_RESULT, 1'b1, VAD_SPEECH, 1'b1);
		it.word_index = '1;
		it.model_index = '1;
		it.volume_word = '1;
		send(it);
		send(make_item(ACT_RESULT, 1'b1, VAD_SILENCE, 1'b1));
		// A zero window starts no timer, so a tick does nothing.
		send_ticks(1);
		settle();

		// Short windows: wake 2, sleep 1, speech confirm 1, silence confirm 1.
		load_windows(24'd2, 24'd1, 24'd1, 24'd1);
		send(make_item(ACT_RESULT, 1'b0, VAD_OTHER, 1'b1));
		it = make_item(ACT_RESULT, 1'b1, VAD_OTHER, 1'b1);
		it.word_index = '0;
		it.model_index = '0;
		it.volume_word = '0;
		send(it);
		// Confirmed speech start, then confirmed speech end into the sleep wait,
		// then the sleep window runs out.
		send(make_item(ACT_RESULT, 1'b0, VAD_SPEECH, 1'b1));
		send_ticks(1);
		send(make_item(ACT_RESULT, 1'b0, VAD_SILENCE, 1'b1));
		send_ticks(2);
		// Both counters run out on one tick while waiting for speech: the wake
		// expiry wins and cancels the pending speech confirmation.
		send(make_item(ACT_RESULT, 1'b1, VAD_SILENCE, 1'b1));
		send_ticks(1);
		send(make_item(ACT_RESULT, 1'b0, VAD_SPEECH, 1'b1));
		send_ticks(1);
		// The wake window runs out with no speech at all.
		send(make_item(ACT_RESULT, 1'b1, VAD_SPEECH, 1'b1));
		send_ticks(2);
		// Speech in idle is ignored while the wake word is required.
		send(make_item(ACT_RESULT, 1'b0, VAD_SPEECH, 1'b1));

		// Random phases. Each one starts from a drained block with a fresh set
		// of windows; the first two use the extremes, the last has no idling.
		for (int p = 0; p < PHASES; p++) begin
			settle();
			if (p == 0)
				load_windows(WINDOW_MAX, WINDOW_MAX, WINDOW_MAX, WINDOW_MAX);
			else if (p == 1)
				load_windows('0, '0, '0, '0);
			else
				load_windows(pick_window(), pick_window(), pick_window(), pick_window());
			mode_wake_en = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 2))
				0: gap_odds = 0;
				1: gap_odds = 3;
				default: gap_odds = 8;
			endcase
			if (p == PHASES - 1)
				gap_odds = 0;
			// Hold the result side off once while items keep coming.
			if (p == 3)
				hold_req = 1;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				if ($urandom_range(0, 3) != 0)
					run_session();
				else
					send_noise();
			end
		end

		settle();
		if (board.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
